@@ rtl/dpr_pkg.sv @@
// Shared constants and types for the disparity reprojection block.
`default_nettype none
package dpr_pkg;
    localparam int unsigned MaxWidthDef  = 4096;
    localparam int unsigned MaxHeightDef = 4096;
    localparam int unsigned ProdW = 36;
    localparam int unsigned LatW  = 53;
    localparam logic [1:0] RegCenterU   = 2'd0;
    localparam logic [1:0] RegCenterV   = 2'd1;
    localparam logic [1:0] RegFocal     = 2'd2;
    localparam logic [1:0] RegBaseline  = 2'd3;
    localparam logic [15:0] FocalReset    = 16'd8000;
    localparam logic [19:0] BaselineReset = 20'd6554;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       point_valid;
        logic       neg_u;
        logic       neg_v;
    } side_t;
endpackage
`default_nettype wire

@@ rtl/dpr_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, stall-aware.
`default_nettype none
module dpr_divider #(
    parameter int unsigned NumW = 36,
    parameter int unsigned DenW = 16,
    parameter int unsigned TagW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [NumW-1:0] in_num,
    input  wire logic [DenW-1:0] in_den,
    input  wire logic [TagW-1:0] in_tag,
    output logic                 out_valid,
    output logic [NumW-1:0]      out_quo,
    output logic [TagW-1:0]      out_tag
);
    logic [NumW:0]   valid_reg;
    logic [NumW-1:0] num_reg [NumW+1];
    logic [DenW:0]   rem_reg [NumW+1];
    logic [DenW-1:0] den_reg [NumW+1];
    logic [TagW-1:0] tag_reg [NumW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NumW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= in_num;
            rem_reg[0] <= '0;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 0; s < NumW; s++)
    begin : g_stage
        logic [DenW:0] trial;
        logic          take;
        assign trial = {rem_reg[s][DenW-1:0], num_reg[s][NumW-1]};
        assign take  = trial >= {1'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? (trial - {1'b0, den_reg[s]}) : trial;
                num_reg[s+1] <= {num_reg[s][NumW-2:0], take};
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[NumW];
    assign out_quo   = num_reg[NumW];
    assign out_tag   = tag_reg[NumW];
endmodule
`default_nettype wire

@@ rtl/disparity_to_point_reprojection_top.sv @@
// Top level of the stereo disparity to 3D point reprojection pipeline.
// Usage:
//   The input channel (in_valid/in_ready) takes one pixel per transaction:
//   column, row, signed disparity in 1/16 pixel and a colour. The output
//   channel (out_valid/out_ready) delivers one point per pixel in order.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
// Throughput and stages:
//   One transaction per cycle is sustained when the output is not stalled.
//   The stages: one input stage, a depth divider of 37 stages (an entry
//   stage and one per quotient bit), the lateral multiply stage, two
//   lateral dividers of 54 stages each running side by side, and a
//   saturation/output stage. The divider chains, one quotient bit per
//   stage, set the latency.
// Reset:
//   rst_n clears all valid bits and restores the register defaults
//   (focal length 8000, baseline 6554, centres zero).
// Stalls:
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready falls; no transaction is lost or repeated. A pipeline
//   that holds no waiting result keeps accepting through the stall.
`default_nettype none
module disparity_to_point_reprojection_top #(
    parameter int unsigned MAX_WIDTH  = dpr_pkg::MaxWidthDef,
    parameter int unsigned MAX_HEIGHT = dpr_pkg::MaxHeightDef
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [19:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  column,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0] row,
    input  wire logic signed [15:0] disparity,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      x_pos,
    output logic signed [31:0]      y_pos,
    output logic [31:0]             depth,
    output logic                    point_valid,
    output logic [7:0]              red_out,
    output logic [7:0]              green_out,
    output logic [7:0]              blue_out
);
    localparam int unsigned CuW = $clog2(MAX_WIDTH) + 4;
    localparam int unsigned CvW = $clog2(MAX_HEIGHT) + 4;
    localparam int unsigned CmW = (CuW > CvW) ? CuW : CvW;
    localparam int unsigned DW  = ((CmW > 16) ? CmW : 16) + 1;
    localparam int unsigned ProdW = dpr_pkg::ProdW;
    localparam int unsigned LatW  = dpr_pkg::LatW;
    localparam int unsigned SideW = $bits(dpr_pkg::side_t);
    localparam int unsigned TagAW = SideW + 2 * 17;

    logic [15:0] center_u_reg, center_v_reg, focal_reg;
    logic [19:0] baseline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_u_reg <= '0;
            center_v_reg <= '0;
            focal_reg    <= dpr_pkg::FocalReset;
            baseline_reg <= dpr_pkg::BaselineReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpr_pkg::RegCenterU:  center_u_reg <= cfg_data[15:0];
                dpr_pkg::RegCenterV:  center_v_reg <= cfg_data[15:0];
                dpr_pkg::RegFocal:    focal_reg    <= cfg_data[15:0];
                dpr_pkg::RegBaseline: baseline_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global enable: the pipeline advances unless a result is held.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage 1: B*F product, disparity divisor (1 for a non-positive disparity), lateral offsets.
    logic                  s1_valid_reg;
    logic [ProdW-1:0]      s1_prod_reg;
    logic [15:0]           s1_disp_reg;
    dpr_pkg::side_t        s1_side_reg;
    logic [16:0]           s1_mu_reg, s1_mv_reg;
    logic signed [DW-1:0]  du_w, dv_w;
    logic                  pos;

    assign pos  = !disparity[15] && (disparity != 16'sd0);
    assign du_w = $signed({{(DW-CuW){1'b0}}, column, 4'b0})
                - $signed({{(DW-16){1'b0}}, center_u_reg});
    assign dv_w = $signed({{(DW-CvW){1'b0}}, row, 4'b0})
                - $signed({{(DW-16){1'b0}}, center_v_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    logic [DW-1:0] mu_w, mv_w;
    assign mu_w = du_w[DW-1] ? DW'(-du_w) : DW'(du_w);
    assign mv_w = dv_w[DW-1] ? DW'(-dv_w) : DW'(dv_w);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= ProdW'(baseline_reg) * ProdW'(focal_reg);
            s1_disp_reg <= pos ? disparity : 16'd1;
            s1_side_reg.red   <= red;
            s1_side_reg.green <= green;
            s1_side_reg.blue  <= blue;
            s1_side_reg.point_valid <= pos;
            s1_side_reg.neg_u <= du_w[DW-1];
            s1_side_reg.neg_v <= dv_w[DW-1];
            s1_mu_reg <= 17'(mu_w);
            s1_mv_reg <= 17'(mv_w);
        end
    end

    // Depth divider.
    logic                 z_valid;
    logic [ProdW-1:0]     z_quo;
    logic [TagAW-1:0]     z_tag;
    dpr_divider #(.NumW(ProdW), .DenW(16), .TagW(TagAW)) u_zdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s1_valid_reg), .in_num(s1_prod_reg), .in_den(s1_disp_reg),
        .in_tag({s1_side_reg, s1_mu_reg, s1_mv_reg}),
        .out_valid(z_valid), .out_quo(z_quo), .out_tag(z_tag)
    );

    // Stage 2: lateral products and depth saturation.
    logic               s2_valid_reg;
    logic [LatW-1:0]    s2_pu_reg, s2_pv_reg;
    logic [31:0]        s2_depth_reg;
    dpr_pkg::side_t     s2_side_reg;
    logic [15:0]        s2_f_reg;
    dpr_pkg::side_t     z_side;
    logic [16:0]        z_mu, z_mv;
    assign {z_side, z_mu, z_mv} = z_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= z_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pu_reg    <= LatW'(z_mu) * LatW'(z_quo);
            s2_pv_reg    <= LatW'(z_mv) * LatW'(z_quo);
            s2_depth_reg <= (z_quo[ProdW-1:32] != '0) ? 32'hFFFF_FFFF : z_quo[31:0];
            s2_side_reg  <= z_side;
            s2_f_reg     <= (focal_reg == 16'd0) ? 16'd1 : focal_reg;
        end
    end

    // Lateral dividers.
    logic              lu_valid, lv_valid;
    logic [LatW-1:0]   lu_quo, lv_quo;
    logic [SideW+32-1:0] lu_tag;
    logic              lv_tag;
    dpr_divider #(.NumW(LatW), .DenW(16), .TagW(SideW + 32)) u_udiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s2_valid_reg), .in_num(s2_pu_reg), .in_den(s2_f_reg),
        .in_tag({s2_side_reg, s2_depth_reg}),
        .out_valid(lu_valid), .out_quo(lu_quo), .out_tag(lu_tag)
    );
    dpr_divider #(.NumW(LatW), .DenW(16), .TagW(1)) u_vdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s2_valid_reg), .in_num(s2_pv_reg), .in_den(s2_f_reg),
        .in_tag(s2_valid_reg),
        .out_valid(lv_valid), .out_quo(lv_quo), .out_tag(lv_tag)
    );

    // Output stage: sign, saturate, zero invalid points.
    dpr_pkg::side_t o_side;
    logic [31:0]    o_depth;
    assign {o_side, o_depth} = lu_tag;

    function automatic logic [31:0] sat_mag(input logic [LatW-1:0] q, input logic neg);
        begin
            if (neg)
                sat_mag = (q > LatW'(33'h8000_0000)) ? 32'h8000_0000 : 32'(-q);
            else
                sat_mag = (q > LatW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

    logic        out_valid_reg, pv_reg;
    logic [31:0] x_reg, y_reg, d_reg;
    logic [7:0]  r_reg, g_reg, b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lu_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pv_reg <= o_side.point_valid;
            x_reg  <= o_side.point_valid ? sat_mag(lu_quo, o_side.neg_u) : 32'd0;
            y_reg  <= o_side.point_valid ? sat_mag(lv_quo, o_side.neg_v) : 32'd0;
            d_reg  <= o_side.point_valid ? o_depth : 32'd0;
            r_reg  <= o_side.red;
            g_reg  <= o_side.green;
            b_reg  <= o_side.blue;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_pos       = x_reg;
    assign y_pos       = y_reg;
    assign depth       = d_reg;
    assign point_valid = pv_reg;
    assign red_out     = r_reg;
    assign green_out   = g_reg;
    assign blue_out    = b_reg;

    // The two lateral dividers run in lock step.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lu_valid == lv_valid) else $error("lateral dividers out of step");
    a_lockstep_tag: assert property (@(posedge clk) disable iff (!rst_n)
        lv_valid |-> lv_tag) else $error("lateral tag mismatch");
    // A held result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_pos) && $stable(depth))
        else $error("held result changed");
    // An invalid point always carries zero coordinates.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> x_pos == 0 && y_pos == 0 && depth == 0)
        else $error("invalid point with nonzero coordinates");
endmodule
`default_nettype wire
